>>> rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared sizes, codes and entry type of the sorted id table.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int DEPTH    = 16;
   localparam int ID_W     = 16;
   localparam int HANDLE_W = 16;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(DEPTH + 1);
   localparam int ENTRY_W  = ID_W + HANDLE_W;

   typedef enum logic [1:0] {
      ACT_INSTALL   = 2'd0,
      ACT_UNINSTALL = 2'd1,
      ACT_LOOKUP    = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] hnd;
   } entry_type;

endpackage

>>> rtl/sorted_id_table_core.sv
// ----------------------------------------------------------------------------
// sorted_id_table_core
// Sorted id/handle table: binary search, insert and remove by shifting
// entries through one RAM with a single read and a single write port.
// The longest item is an automatic id into a table one short of full: gap
// scan and shift together cover every entry, then an insert.
// One item at a time; the RAM read port paces search, gap scan and shifts,
// one entry per cycle during a shift.
// Reset clears the entry count and the result valid; the RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_id_table_core
   import sit_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [ID_W-1:0]     req_device_id,
   input  logic [HANDLE_W-1:0] req_handle,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [CW-1:0]       rsp_position,
   output logic [ID_W-1:0]     rsp_assigned_id,
   output logic [HANDLE_W-1:0] rsp_found_handle,
   output logic [CW-1:0]       rsp_entry_count
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_ALAST   = 12'b000000000010,
      S_GAP     = 12'b000000000100,
      S_SRCH    = 12'b000000001000,
      S_SCMP    = 12'b000000010000,
      S_DECIDE  = 12'b000000100000,
      S_INS     = 12'b000001000000,
      S_INS_MV  = 12'b000010000000,
      S_INS_PUT = 12'b000100000000,
      S_DEL     = 12'b001000000000,
      S_DEL_MV  = 12'b010000000000,
      S_DONE    = 12'b100000000000
   } state_type;

   localparam logic [ID_W-1:0] MAX_ID = '1;

   state_type           state_ff, state_in;
   logic [1:0]          act_ff, act_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [HANDLE_W-1:0] hnd_ff, hnd_in;
   logic [HANDLE_W-1:0] fh_ff, fh_in;
   logic                found_ff, found_in;
   status_type          status_ff, status_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       mid_ff, mid_in;
   logic [CW-1:0]       k_ff, k_in;
   logic [CW-1:0]       pos_ff, pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          rsp_status_ff, rsp_status_in;
   logic [CW-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [HANDLE_W-1:0] rsp_fh_ff, rsp_fh_in;
   logic [CW-1:0]       rsp_cnt_ff, rsp_cnt_in;

   logic                wr_en;
   logic [CW-1:0]       wr_idx;
   logic [CW-1:0]       rd_idx;
   entry_type           wr_entry;
   entry_type           rd_entry;
   logic [ENTRY_W-1:0]  rd_data;

   logic [CW:0]         lohi_sum;
   logic [CW-1:0]       mid_calc;
   logic [CW-1:0]       k_dec, k_dec2, k_inc, k_inc2, cnt_dec, cnt_inc;
   logic [ID_W-1:0]     gap_cand;
   logic [ID_W:0]       auto_next;

   assign lohi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = lohi_sum[CW:1];
   assign k_dec     = k_ff - CW'(1);
   assign k_dec2    = k_ff - CW'(2);
   assign k_inc     = k_ff + CW'(1);
   assign k_inc2    = k_ff + CW'(2);
   assign cnt_dec   = cnt_ff - CW'(1);
   assign cnt_inc   = cnt_ff + CW'(1);
   assign gap_cand  = ID_W'(k_ff) + ID_W'(1);
   assign auto_next = {1'b0, ID_W'(cnt_ff)} + (ID_W + 1)'(1);
   assign rd_entry  = entry_type'(rd_data);

   sit_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      id_in     = id_ff;
      hnd_in    = hnd_ff;
      fh_in     = fh_ff;
      found_in  = found_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      k_in      = k_ff;
      pos_in    = pos_ff;
      wr_en     = 1'b0;
      wr_idx    = k_ff;
      wr_entry  = rd_entry;
      rd_idx    = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_fh_in     = rsp_fh_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in    = req_action;
               id_in     = req_device_id;
               hnd_in    = req_handle;
               fh_in     = '0;
               found_in  = 1'b0;
               pos_in    = '0;
               lo_in     = '0;
               hi_in     = cnt_ff;
               status_in = ST_NOTFOUND;
               priority if (req_action == ACT_INSTALL && req_device_id == '0) begin
                  if (cnt_ff == '0) begin
                     id_in    = ID_W'(1);
                     state_in = S_SRCH;
                  end else begin
                     rd_idx   = cnt_dec;
                     state_in = S_ALAST;
                  end
               end else if (req_action == ACT_INSTALL || req_action == ACT_UNINSTALL ||
                            req_action == ACT_LOOKUP) begin
                  state_in = S_SRCH;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_ALAST: begin
            if (rd_entry.id != MAX_ID) begin
               id_in    = rd_entry.id + ID_W'(1);
               state_in = S_SRCH;
            end else begin
               k_in     = '0;
               rd_idx   = '0;
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            priority if (rd_entry.id != gap_cand) begin
               id_in    = gap_cand;
               state_in = S_SRCH;
            end else if (k_inc == cnt_ff) begin
               if (auto_next > {1'b0, MAX_ID}) begin
                  id_in     = '0;
                  pos_in    = '0;
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  id_in    = auto_next[ID_W-1:0];
                  state_in = S_SRCH;
               end
            end else begin
               k_in   = k_inc;
               rd_idx = k_inc;
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_calc;
               rd_idx   = mid_calc;
               state_in = S_SCMP;
            end else begin
               pos_in   = lo_ff;
               found_in = 1'b0;
               state_in = S_DECIDE;
            end
         end
         S_SCMP: begin
            priority if (id_ff < rd_entry.id) begin
               hi_in    = mid_ff;
               state_in = S_SRCH;
            end else if (id_ff > rd_entry.id) begin
               lo_in    = mid_ff + CW'(1);
               state_in = S_SRCH;
            end else begin
               pos_in   = mid_ff;
               found_in = 1'b1;
               fh_in    = rd_entry.hnd;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            unique case (act_ff)
               ACT_INSTALL: begin
                  priority if (found_ff) begin
                     status_in = ST_DUP;
                  end else if (cnt_ff == CW'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     k_in     = cnt_ff;
                     state_in = S_INS;
                  end
               end
               ACT_UNINSTALL: begin
                  priority if (!found_ff) begin
                     status_in = ST_NOTFOUND;
                  end else if (fh_ff != hnd_ff) begin
                     status_in = ST_MISMATCH;
                  end else begin
                     k_in     = pos_ff;
                     state_in = S_DEL;
                  end
               end
               ACT_LOOKUP: begin
                  status_in = found_ff ? ST_OK : ST_NOTFOUND;
               end
               default: begin
                  status_in = ST_NOTFOUND;
               end
            endcase
         end
         S_INS: begin
            if (k_ff > pos_ff) begin
               rd_idx   = k_dec;
               state_in = S_INS_MV;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_MV: begin
            wr_en    = 1'b1;
            wr_idx   = k_ff;
            wr_entry = rd_entry;
            k_in     = k_dec;
            if (k_dec > pos_ff) begin
               rd_idx = k_dec2;
            end else begin
               state_in = S_INS_PUT;
            end
         end
         S_INS_PUT: begin
            wr_en     = 1'b1;
            wr_idx    = pos_ff;
            wr_entry  = '{id: id_ff, hnd: hnd_ff};
            cnt_in    = cnt_inc;
            status_in = ST_OK;
            state_in  = S_DONE;
         end
         S_DEL: begin
            if (k_inc < cnt_ff) begin
               rd_idx   = k_inc;
               state_in = S_DEL_MV;
            end else begin
               cnt_in    = cnt_dec;
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_DEL_MV: begin
            wr_en    = 1'b1;
            wr_idx   = k_ff;
            wr_entry = rd_entry;
            k_in     = k_inc;
            if (k_inc2 < cnt_ff) begin
               rd_idx = k_inc2;
            end else begin
               cnt_in    = cnt_dec;
               status_in = ST_OK;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pos_in    = pos_ff;
               rsp_id_in     = id_ff;
               rsp_fh_in     = (act_ff == ACT_LOOKUP && status_ff == ST_OK) ? fh_ff : '0;
               rsp_cnt_in    = cnt_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      id_ff         <= id_in;
      hnd_ff        <= hnd_in;
      fh_ff         <= fh_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      k_ff          <= k_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_fh_ff     <= rsp_fh_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_assigned_id  = rsp_id_ff;
   assign rsp_found_handle = rsp_fh_ff;
   assign rsp_entry_count  = rsp_cnt_ff;

endmodule

>>> rtl/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_id_table_core. Directed install, uninstall
// and lookup items cover the empty and full table, automatic ids with and
// without a gap scan, duplicates, handle mismatches and the unused action.
// Random items follow, growing and shrinking the table in turns. A shadow
// table predicts every result, and results are checked field by field in
// order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import sit_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam longint MAX_ID = (longint'(1) << ID_W) - 1;
   localparam int RANDOM_ITEMS = 1420;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_PRINTED = 100;

   typedef struct {
      logic [1:0]          action;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] hnd;
   } request_t;

   typedef struct {
      status_type          status;
      logic [CW-1:0]       position;
      logic [ID_W-1:0]     assigned_id;
      logic [HANDLE_W-1:0] found_handle;
      logic [CW-1:0]       entry_count;
   } outcome_t;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_action = '0;
   logic [ID_W-1:0]     req_device_id = '0;
   logic [HANDLE_W-1:0] req_handle = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [2:0]          rsp_status;
   logic [CW-1:0]       rsp_position;
   logic [ID_W-1:0]     rsp_assigned_id;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic [CW-1:0]       rsp_entry_count;

   // shadow of the table
   logic [ID_W-1:0]     tbl_id [DEPTH];
   logic [HANDLE_W-1:0] tbl_hnd [DEPTH];
   int                  tbl_count = 0;

   request_t pending_requests[$];
   outcome_t expected_replies[$];
   request_t next_req;
   outcome_t head_reply;
   bit       steady = 1'b0;
   int       errors = 0;
   int       replies = 0;
   int       cycles = 0;

   sorted_id_table_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_device_id    (req_device_id),
      .req_handle       (req_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_assigned_id  (rsp_assigned_id),
      .rsp_found_handle (rsp_found_handle),
      .rsp_entry_count  (rsp_entry_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit find_id(input logic [ID_W-1:0] id, output int pos);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = tbl_count;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (id < tbl_id[mid]) hi = mid;
         else if (id > tbl_id[mid]) lo = mid + 1;
         else begin
            pos = mid;
            return 1'b1;
         end
      end
      pos = lo;
      return 1'b0;
   endfunction

   // may exceed the largest id when every id is taken
   function automatic longint next_free_id();
      longint cand;
      if (tbl_count == 0) return 1;
      if (tbl_id[tbl_count-1] < MAX_ID) return longint'(tbl_id[tbl_count-1]) + 1;
      cand = 1;
      for (int p = 0; p < tbl_count; p++) begin
         if (cand != longint'(tbl_id[p])) return cand;
         cand++;
      end
      return cand;
   endfunction

   function automatic outcome_t table_apply(input request_t q);
      outcome_t o;
      logic [ID_W-1:0] id;
      int pos;
      longint a;
      bit exhausted;
      id = q.id;
      pos = 0;
      exhausted = 1'b0;
      o.status = ST_NOTFOUND;
      o.found_handle = '0;
      case (q.action)
         ACT_INSTALL: begin
            if (id == '0) begin
               a = next_free_id();
               if (a > MAX_ID) exhausted = 1'b1;
               else id = a[ID_W-1:0];
            end
            if (exhausted) o.status = ST_FULL;
            else if (find_id(id, pos)) o.status = ST_DUP;
            else if (tbl_count >= DEPTH) o.status = ST_FULL;
            else begin
               for (int k = tbl_count; k > pos; k--) begin
                  tbl_id[k] = tbl_id[k-1];
                  tbl_hnd[k] = tbl_hnd[k-1];
               end
               tbl_id[pos] = id;
               tbl_hnd[pos] = q.hnd;
               tbl_count++;
               o.status = ST_OK;
            end
         end
         ACT_UNINSTALL: begin
            if (!find_id(id, pos)) o.status = ST_NOTFOUND;
            else if (tbl_hnd[pos] != q.hnd) o.status = ST_MISMATCH;
            else begin
               for (int k = pos; k + 1 < tbl_count; k++) begin
                  tbl_id[k] = tbl_id[k+1];
                  tbl_hnd[k] = tbl_hnd[k+1];
               end
               tbl_count--;
               o.status = ST_OK;
            end
         end
         ACT_LOOKUP: begin
            if (find_id(id, pos)) begin
               o.status = ST_OK;
               o.found_handle = tbl_hnd[pos];
            end
         end
         default: ;
      endcase
      o.position = pos[CW-1:0];
      o.assigned_id = exhausted ? '0 : id;
      o.entry_count = tbl_count[CW-1:0];
      return o;
   endfunction

   function automatic logic [ID_W-1:0] random_id();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(7))
         0: return ID_W'($urandom_range(1, 40));
         1: return ID_W'(MAX_ID - $urandom_range(0, 24));
         2: return ID_W'(MAX_ID);
         default: return w[ID_W-1:0];
      endcase
   endfunction

   function automatic logic [HANDLE_W-1:0] random_handle();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return w[HANDLE_W-1:0];
      endcase
   endfunction

   function automatic request_t random_request(input bit grow);
      request_t q;
      int r;
      int j;
      int ins_cut;
      int del_cut;
      r = $urandom_range(99);
      ins_cut = grow ? 55 : 15;
      del_cut = ins_cut + (grow ? 15 : 45);
      q.id = random_id();
      q.hnd = random_handle();
      if (r < ins_cut) begin
         q.action = ACT_INSTALL;
         if ($urandom_range(3) == 0) q.id = '0;
         else if (tbl_count > 0 && $urandom_range(7) == 0)
            q.id = tbl_id[$urandom_range(tbl_count - 1)];
      end else if (r < del_cut) begin
         q.action = ACT_UNINSTALL;
         if (tbl_count > 0 && $urandom_range(3) != 0) begin
            j = $urandom_range(tbl_count - 1);
            q.id = tbl_id[j];
            if ($urandom_range(4) != 0) q.hnd = tbl_hnd[j];
         end
      end else if (r < 97) begin
         q.action = ACT_LOOKUP;
         if (tbl_count > 0 && $urandom_range(1) == 0)
            q.id = tbl_id[$urandom_range(tbl_count - 1)];
      end else begin
         q.action = ACT_UNUSED;
      end
      return q;
   endfunction

   task automatic queue_request(input logic [1:0] act, input logic [ID_W-1:0] id,
                                input logic [HANDLE_W-1:0] hnd);
      request_t q;
      q.action = act;
      q.id = id;
      q.hnd = hnd;
      pending_requests.push_back(q);
   endtask

   task automatic drain();
      while (pending_requests.size() != 0 || req_valid || expected_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      errors++;
      if (errors <= MAX_PRINTED)
         $display("cycle %0d item %0d: %s got 0x%0h expected 0x%0h",
                  cycles, replies, what, got, want);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            next_req.action = req_action;
            next_req.id = req_device_id;
            next_req.hnd = req_handle;
            expected_replies.push_back(table_apply(next_req));
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_action <= next_req.action;
               req_device_id <= next_req.id;
               req_handle <= next_req.hnd;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected item, status", rsp_status, 0);
            end else begin
               head_reply = expected_replies.pop_front();
               if (rsp_status !== head_reply.status)
                  report_mismatch("status", rsp_status, head_reply.status);
               if (rsp_position !== head_reply.position)
                  report_mismatch("position", rsp_position, head_reply.position);
               if (rsp_assigned_id !== head_reply.assigned_id)
                  report_mismatch("assigned_id", rsp_assigned_id, head_reply.assigned_id);
               if (rsp_found_handle !== head_reply.found_handle)
                  report_mismatch("found_handle", rsp_found_handle, head_reply.found_handle);
               if (rsp_entry_count !== head_reply.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, head_reply.entry_count);
            end
            replies++;
         end
         rsp_ready <= steady || ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty table, automatic ids, gap scan behind the largest id
      queue_request(ACT_LOOKUP, 16'd5, 16'h0000);
      queue_request(ACT_UNINSTALL, 16'd7, 16'hFFFF);
      queue_request(ACT_INSTALL, 16'd0, 16'hFFFF);
      queue_request(ACT_INSTALL, 16'd0, 16'h0000);
      queue_request(ACT_INSTALL, 16'hFFFF, 16'h1234);
      queue_request(ACT_INSTALL, 16'd0, 16'h5A5A);
      queue_request(ACT_INSTALL, 16'hFFFF, 16'h0000);
      queue_request(ACT_INSTALL, 16'h8000, 16'hAAAA);
      queue_request(ACT_LOOKUP, 16'h8000, 16'h0000);
      queue_request(ACT_UNINSTALL, 16'h8000, 16'h5555);
      queue_request(ACT_UNINSTALL, 16'h8000, 16'hAAAA);
      queue_request(ACT_UNUSED, 16'hBEEF, 16'h4321);
      queue_request(ACT_LOOKUP, 16'd0, 16'h0000);
      // fill the table, then hit it while full
      for (int n = 0; n < 12; n++) queue_request(ACT_INSTALL, 16'd0, random_handle());
      queue_request(ACT_INSTALL, 16'd100, 16'h0F0F);
      queue_request(ACT_INSTALL, 16'hFFFF, 16'h1234);
      queue_request(ACT_INSTALL, 16'd0, 16'hF0F0);
      drain();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 500 && n < 800);
         if (n % 350 == 349) drain();
         while (pending_requests.size() != 0) @(negedge clock);
         pending_requests.push_back(random_request(((n / 120) % 2) == 1));
      end
      steady = 1'b0;

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/sit_pkg.sv
rtl/sit_ram.sv
rtl/sorted_id_table_core.sv
tb/testbench.sv
